// ===== rtl/stmc_pkg.sv =====
// Shared constants for the shadow tag memory checker.
// Operation and status codes, store geometry and tag width.
// No dependencies.
package stmc_pkg;

  localparam int ADDR_W       = 16;
  localparam int SHADOW_BYTES = 1 << ADDR_W;
  localparam int TAG_BITS     = 7;
  localparam int TAG_W        = 7;
  localparam int VAL_W        = 8;
  localparam int STATUS_W     = 3;

  localparam logic [TAG_W-1:0] TAG_MASK = TAG_W'((1 << TAG_BITS) - 1);

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_ACCESS = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DOUBLE_ALLOC = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DOUBLE_FREE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_AFTER_FREE  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE       = 3'd4;

endpackage

// ===== rtl/shadow_tag_memory_checker_core.sv =====
// Shadow tag memory checker: one shadow byte per address, sequenced checks and fills.
// Holds the shadow RAM and its sequencer.
// Depends on stmc_pkg.

// After reset the block sweeps the shadow RAM to zero, one byte a cycle, with
// busy_o high. A request is taken when start_i is high and busy_o is low.
// Allocate and free make one pass to check and one pass to write; access makes
// the check pass only; a mismatch ends the check pass early. Out-of-range
// requests and the unused op code answer on the next cycle. The rate is set by
// the single read/write port of the shadow RAM, which touches one byte per
// cycle. Each result is shown for one cycle with done_o high and cannot be held
// off.
module shadow_tag_memory_checker_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    op_i,
  input  logic [15:0]                   offset_i,
  input  logic [15:0]                   length_i,
  input  logic [6:0]                    tag_i,
  output logic                          done_o,
  output logic [stmc_pkg::STATUS_W-1:0] status_o,
  output logic [15:0]                   bad_offset_o,
  output logic [stmc_pkg::VAL_W-1:0]    bad_value_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;

  localparam int AW = stmc_pkg::ADDR_W;
  localparam int VW = stmc_pkg::VAL_W;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [15:0]   cnt_q, cnt_d;
  logic          cmp_vld_q, cmp_vld_d;
  logic [AW-1:0] cmp_addr_q;
  logic [VW-1:0] rd_data_q;
  logic          done_q, done_d;

  logic [1:0]    op_q, op_d;
  logic [AW-1:0] off_q, off_d;
  logic [15:0]   len_q, len_d;
  logic [VW-1:0] want_q, want_d;
  logic [VW-1:0] wval_q, wval_d;
  logic [stmc_pkg::STATUS_W-1:0] err_q, err_d;

  logic [stmc_pkg::STATUS_W-1:0] status_q, status_d;
  logic [15:0]   bad_off_q, bad_off_d;
  logic [VW-1:0] bad_val_q, bad_val_d;

  logic          accept;
  logic [16:0]   range_end;
  logic [VW-1:0] tag_mark;
  logic          mismatch;
  logic          rd_en;
  logic          wr_en;
  logic [VW-1:0] wr_data;

  logic [VW-1:0] mem_q [stmc_pkg::SHADOW_BYTES];

  assign busy_o    = (state_q != S_IDLE);
  assign accept    = start_i && !busy_o;
  assign range_end = {1'b0, offset_i} + {1'b0, length_i};
  assign tag_mark  = {1'b0, tag_i & stmc_pkg::TAG_MASK} + VW'(1);
  assign mismatch  = cmp_vld_q && (rd_data_q != want_q);

  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    cnt_d     = cnt_q;
    cmp_vld_d = 1'b0;
    done_d    = 1'b0;
    op_d      = op_q;
    off_d     = off_q;
    len_d     = len_q;
    want_d    = want_q;
    wval_d    = wval_q;
    err_d     = err_q;
    status_d  = status_q;
    bad_off_d = bad_off_q;
    bad_val_d = bad_val_q;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    wr_data   = wval_q;

    case (state_q)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = '0;
        addr_d  = addr_q + AW'(1);
        if (addr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_d   = op_i;
          off_d  = offset_i;
          len_d  = length_i;
          addr_d = offset_i;
          cnt_d  = length_i;
          case (op_i)
            stmc_pkg::OP_ALLOC: begin
              want_d = '0;
              wval_d = tag_mark;
              err_d  = stmc_pkg::ST_DOUBLE_ALLOC;
            end
            stmc_pkg::OP_FREE: begin
              want_d = tag_mark;
              wval_d = '0;
              err_d  = stmc_pkg::ST_DOUBLE_FREE;
            end
            default: begin
              want_d = tag_mark;
              wval_d = '0;
              err_d  = stmc_pkg::ST_AFTER_FREE;
            end
          endcase
          if (op_i != stmc_pkg::OP_ALLOC && op_i != stmc_pkg::OP_FREE &&
              op_i != stmc_pkg::OP_ACCESS) begin
            done_d    = 1'b1;
            status_d  = stmc_pkg::ST_OK;
            bad_off_d = '0;
            bad_val_d = '0;
          end else if (range_end[16]) begin
            done_d    = 1'b1;
            status_d  = stmc_pkg::ST_RANGE;
            bad_off_d = offset_i;
            bad_val_d = '0;
          end else begin
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        // reads run one ahead of the compare
        rd_en = (cnt_q != '0);
        if (rd_en) begin
          addr_d    = addr_q + AW'(1);
          cnt_d     = cnt_q - 16'd1;
          cmp_vld_d = 1'b1;
        end
        if (mismatch) begin
          state_d   = S_IDLE;
          done_d    = 1'b1;
          status_d  = err_q;
          bad_off_d = cmp_addr_q;
          bad_val_d = rd_data_q;
        end else if (cnt_q == '0) begin
          addr_d = off_q;
          cnt_d  = len_q;
          if (op_q == stmc_pkg::OP_ACCESS) begin
            state_d   = S_IDLE;
            done_d    = 1'b1;
            status_d  = stmc_pkg::ST_OK;
            bad_off_d = '0;
            bad_val_d = '0;
          end else begin
            state_d = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        if (cnt_q != '0) begin
          wr_en  = 1'b1;
          addr_d = addr_q + AW'(1);
          cnt_d  = cnt_q - 16'd1;
        end else begin
          state_d   = S_IDLE;
          done_d    = 1'b1;
          status_d  = stmc_pkg::ST_OK;
          bad_off_d = '0;
          bad_val_d = '0;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      addr_q    <= '0;
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      addr_q    <= addr_d;
      cnt_q     <= cnt_d;
      cmp_vld_q <= cmp_vld_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    off_q      <= off_d;
    len_q      <= len_d;
    want_q     <= want_d;
    wval_q     <= wval_d;
    err_q      <= err_d;
    status_q   <= status_d;
    bad_off_q  <= bad_off_d;
    bad_val_q  <= bad_val_d;
    cmp_addr_q <= addr_q;
  end

  // shadow RAM: one port, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[addr_q] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[addr_q];
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign bad_offset_o = bad_off_q;
  assign bad_value_o  = bad_val_q;

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy_o || done_o))
    else $error("accepted request made no progress");

  a_ok_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == stmc_pkg::ST_OK) |-> (bad_offset_o == '0 && bad_value_o == '0))
    else $error("ok result with nonzero error fields");

  a_range_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == stmc_pkg::ST_RANGE) |-> (bad_value_o == '0))
    else $error("range error with nonzero value");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == S_CLEAR || state_q == S_WRITE))
    else $error("shadow write outside clear or write pass");

  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o || start_i))
    else $error("result without a request");

endmodule

// ===== tb/shadow_tag_memory_checker_core_tb.sv =====
// Testbench for shadow_tag_memory_checker_core: directed table, then random request traffic.
// A mirror predicts verdicts not fixed in the table. Depends on stmc_pkg and the core RTL.
module shadow_tag_memory_checker_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int N_RANDOM = 1875;
  localparam int IDLE_LIMIT = 600000;
  localparam int LIVE_MAX = 40;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] offset;
    logic [15:0] length;
    logic [6:0]  tag;
  } tag_request_t;

  typedef struct packed {
    logic [stmc_pkg::STATUS_W-1:0] status;
    logic [15:0]                   bad_offset;
    logic [stmc_pkg::VAL_W-1:0]    bad_value;
  } tag_verdict_t;

  typedef struct {
    tag_request_t req;
    bit           fixed;
    tag_verdict_t verdict;
  } plan_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          start_i;
  logic                          busy_o;
  logic [1:0]                    op_i;
  logic [15:0]                   offset_i;
  logic [15:0]                   length_i;
  logic [6:0]                    tag_i;
  logic                          done_o;
  logic [stmc_pkg::STATUS_W-1:0] status_o;
  logic [15:0]                   bad_offset_o;
  logic [stmc_pkg::VAL_W-1:0]    bad_value_o;

  logic [7:0]   shadow_mirror [stmc_pkg::SHADOW_BYTES];
  tag_verdict_t pending_verdicts [$];
  plan_row_t    directed_plan [$];
  tag_request_t live_blocks [$];

  int n_accepted = 0;
  int n_checked  = 0;
  int n_flagged  = 0;
  int n_fail     = 0;
  int idle_cycles = 0;

  shadow_tag_memory_checker_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .op_i         (op_i),
    .offset_i     (offset_i),
    .length_i     (length_i),
    .tag_i        (tag_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .bad_offset_o (bad_offset_o),
    .bad_value_o  (bad_value_o)
  );

  always #5 clk_i = ~clk_i;

  // Computes the verdict for one request and applies its writes to the mirror.
  function automatic tag_verdict_t shadow_verdict(input tag_request_t rq);
    int unsigned last;
    int          a;
    logic [7:0]  mark;
    logic [7:0]  want;
    logic [stmc_pkg::STATUS_W-1:0] err;
    tag_verdict_t v;
    v = '0;
    if (rq.op == OP_NONE) return v;
    last = int'(rq.offset) + int'(rq.length);
    if (last >= stmc_pkg::SHADOW_BYTES) begin
      v.status = stmc_pkg::ST_RANGE;
      v.bad_offset = rq.offset;
      return v;
    end
    mark = {1'b0, rq.tag & stmc_pkg::TAG_MASK} + 8'd1;
    want = (rq.op == stmc_pkg::OP_ALLOC) ? 8'd0 : mark;
    err = (rq.op == stmc_pkg::OP_ALLOC) ? stmc_pkg::ST_DOUBLE_ALLOC :
          (rq.op == stmc_pkg::OP_FREE)  ? stmc_pkg::ST_DOUBLE_FREE  :
                                          stmc_pkg::ST_AFTER_FREE;
    for (a = int'(rq.offset); a < last; a++) begin
      if (shadow_mirror[a] != want) begin
        v.status = err;
        v.bad_offset = a[15:0];
        v.bad_value = shadow_mirror[a];
        return v;
      end
    end
    if (rq.op == stmc_pkg::OP_ALLOC) begin
      for (a = int'(rq.offset); a < last; a++) shadow_mirror[a] = mark;
    end else if (rq.op == stmc_pkg::OP_FREE) begin
      for (a = int'(rq.offset); a < last; a++) shadow_mirror[a] = 8'd0;
    end
    return v;
  endfunction

  function automatic tag_request_t make_request(input logic [1:0] op, input int off,
                                                input int len, input int tag);
    tag_request_t rq;
    rq.op = op;
    rq.offset = 16'(off);
    rq.length = 16'(len);
    rq.tag = 7'(tag);
    return rq;
  endfunction

  task automatic add_row(input logic [1:0] op, input int off, input int len, input int tag,
                         input bit fixed, input logic [stmc_pkg::STATUS_W-1:0] st,
                         input int bo, input int bv);
    plan_row_t row;
    row.req = make_request(op, off, len, tag);
    row.fixed = fixed;
    row.verdict.status = st;
    row.verdict.bad_offset = 16'(bo);
    row.verdict.bad_value = 8'(bv);
    directed_plan.push_back(row);
  endtask

  // Called right after a rising edge; returns at the edge that took the request,
  // with start_i still high.
  task automatic issue_request(input tag_request_t rq, input bit fixed,
                               input tag_verdict_t typed, output tag_verdict_t got);
    start_i  <= 1'b1;
    op_i     <= rq.op;
    offset_i <= rq.offset;
    length_i <= rq.length;
    tag_i    <= rq.tag;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    n_accepted++;
    got = shadow_verdict(rq);
    if (fixed) pending_verdicts.push_back(typed);
    else pending_verdicts.push_back(got);
  endtask

  task automatic idle_for(input int cycles);
    if (cycles > 0) begin
      start_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_verdicts.size() != 0);
  endtask

  function automatic int hot_offset();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 511);
      1: return 16'h7F00 + $urandom_range(0, 511);
      2: return 16'hFE00 + $urandom_range(0, 511);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic int block_length();
    if ($urandom_range(0, 19) == 0) return $urandom_range(25, 300);
    return $urandom_range(1, 24);
  endfunction

  function automatic tag_request_t random_request();
    tag_request_t rq;
    tag_request_t blk;
    int kind;
    int r;
    int len;
    kind = $urandom_range(0, 99);
    if (kind < 35 && live_blocks.size() >= LIVE_MAX) kind = 70;
    if (kind >= 35 && kind < 80 && live_blocks.size() == 0) kind = 0;
    if (kind < 35) begin
      rq = make_request(stmc_pkg::OP_ALLOC, hot_offset(), block_length(),
                        $urandom_range(0, 127));
    end else if (kind < 60) begin
      blk = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
      r = $urandom_range(0, int'(blk.length) - 1);
      len = $urandom_range(0, int'(blk.length) - r);
      if ($urandom_range(0, 4) == 0) len += $urandom_range(1, 8);
      rq = make_request(stmc_pkg::OP_ACCESS, int'(blk.offset) + r, len, blk.tag);
      if ($urandom_range(0, 6) == 0) rq.tag = blk.tag ^ 7'($urandom_range(1, 127));
    end else if (kind < 80) begin
      blk = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
      rq = blk;
      rq.op = stmc_pkg::OP_FREE;
      case ($urandom_range(0, 9))
        0: rq.tag = blk.tag ^ 7'($urandom_range(1, 127));
        1: begin
          r = $urandom_range(0, int'(blk.length) - 1);
          rq.offset = blk.offset + 16'(r);
          rq.length = 16'($urandom_range(1, int'(blk.length) - r + 4));
        end
        default: ;
      endcase
    end else begin
      // noise: any op, about half out of range; long in-range walks are trimmed
      rq = make_request(2'($urandom_range(0, 3)), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), $urandom_range(0, 127));
      if (int'(rq.offset) + int'(rq.length) < stmc_pkg::SHADOW_BYTES &&
          rq.length > 16'd1024)
        rq.length = {6'd0, rq.length[9:0]};
    end
    return rq;
  endfunction

  task automatic track_blocks(input tag_request_t rq, input tag_verdict_t v);
    int i;
    if (v.status != stmc_pkg::ST_OK || rq.length == 16'd0) return;
    if (rq.op == stmc_pkg::OP_ALLOC) begin
      live_blocks.push_back(rq);
    end else if (rq.op == stmc_pkg::OP_FREE) begin
      for (i = live_blocks.size() - 1; i >= 0; i--) begin
        if (int'(live_blocks[i].offset) < int'(rq.offset) + int'(rq.length) &&
            int'(rq.offset) < int'(live_blocks[i].offset) + int'(live_blocks[i].length))
          live_blocks.delete(i);
      end
    end
  endtask

  // Result checker: every strobe must match the oldest expectation.
  always @(posedge clk_i) begin
    tag_verdict_t exp_v;
    if (rst_ni && done_o) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result status=%0d bad_offset=%h bad_value=%h",
                 $time, status_o, bad_offset_o, bad_value_o);
        n_fail++;
      end else begin
        exp_v = pending_verdicts.pop_front();
        n_checked++;
        if (exp_v.status != stmc_pkg::ST_OK) n_flagged++;
        if (status_o !== exp_v.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_v.status, status_o);
          n_fail++;
        end
        if (bad_offset_o !== exp_v.bad_offset) begin
          $display("%0t: bad_offset expected %h actual %h", $time, exp_v.bad_offset,
                   bad_offset_o);
          n_fail++;
        end
        if (bad_value_o !== exp_v.bad_value) begin
          $display("%0t: bad_value expected %h actual %h", $time, exp_v.bad_value,
                   bad_value_o);
          n_fail++;
        end
      end
    end
  end

  // Watchdog on cycles without a request taken or a result shown.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog expired, %0d results still due", $time,
               pending_verdicts.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    tag_verdict_t got;
    tag_verdict_t none;
    tag_request_t rq;
    int burst_left;
    int k;
    none = '0;
    burst_left = 0;
    for (k = 0; k < stmc_pkg::SHADOW_BYTES; k++) shadow_mirror[k] = 8'd0;
    rst_ni   <= 1'b0;
    start_i  <= 1'b0;
    op_i     <= stmc_pkg::OP_ALLOC;
    offset_i <= '0;
    length_i <= '0;
    tag_i    <= '0;

    // store is all free after reset
    add_row(stmc_pkg::OP_ACCESS, 0, 1, 0, 1, stmc_pkg::ST_AFTER_FREE, 0, 0);
    add_row(stmc_pkg::OP_FREE, 100, 4, 5, 1, stmc_pkg::ST_DOUBLE_FREE, 100, 0);
    add_row(stmc_pkg::OP_ALLOC, 0, 0, 0, 1, stmc_pkg::ST_OK, 0, 0);
    // range end exactly at the store size is rejected
    add_row(stmc_pkg::OP_ALLOC, 65535, 1, 0, 1, stmc_pkg::ST_RANGE, 65535, 0);
    add_row(stmc_pkg::OP_ALLOC, 65534, 1, 127, 1, stmc_pkg::ST_OK, 0, 0);
    add_row(stmc_pkg::OP_ACCESS, 65534, 1, 127, 1, stmc_pkg::ST_OK, 0, 0);
    add_row(stmc_pkg::OP_ACCESS, 65534, 1, 126, 1, stmc_pkg::ST_AFTER_FREE, 65534, 128);
    add_row(stmc_pkg::OP_ALLOC, 65534, 1, 3, 1, stmc_pkg::ST_DOUBLE_ALLOC, 65534, 128);
    add_row(stmc_pkg::OP_FREE, 65534, 1, 127, 1, stmc_pkg::ST_OK, 0, 0);
    add_row(OP_NONE, 65535, 65535, 127, 1, stmc_pkg::ST_OK, 0, 0);
    add_row(stmc_pkg::OP_ALLOC, 65535, 65535, 127, 1, stmc_pkg::ST_RANGE, 65535, 0);
    add_row(stmc_pkg::OP_ALLOC, 16, 8, 0, 0, stmc_pkg::ST_OK, 0, 0);
    add_row(stmc_pkg::OP_ALLOC, 20, 8, 1, 0, stmc_pkg::ST_OK, 0, 0);
    add_row(stmc_pkg::OP_ACCESS, 16, 8, 0, 0, stmc_pkg::ST_OK, 0, 0);
    add_row(stmc_pkg::OP_ACCESS, 16, 0, 9, 1, stmc_pkg::ST_OK, 0, 0);
    add_row(stmc_pkg::OP_FREE, 16, 4, 0, 0, stmc_pkg::ST_OK, 0, 0);
    add_row(stmc_pkg::OP_ACCESS, 16, 8, 0, 0, stmc_pkg::ST_OK, 0, 0);
    add_row(stmc_pkg::OP_FREE, 20, 4, 0, 0, stmc_pkg::ST_OK, 0, 0);
    add_row(stmc_pkg::OP_ALLOC, 16'h8000, 200, 7'h55, 0, stmc_pkg::ST_OK, 0, 0);
    add_row(stmc_pkg::OP_FREE, 16'h8000, 200, 7'h2A, 0, stmc_pkg::ST_OK, 0, 0);
    add_row(stmc_pkg::OP_FREE, 16'h8000, 200, 7'h55, 0, stmc_pkg::ST_OK, 0, 0);
    // all but the last byte of the store taken and released in one request each
    add_row(stmc_pkg::OP_ALLOC, 0, 65535, 127, 1, stmc_pkg::ST_OK, 0, 0);
    add_row(stmc_pkg::OP_ACCESS, 16'h4321, 3, 127, 1, stmc_pkg::ST_OK, 0, 0);
    add_row(stmc_pkg::OP_FREE, 0, 65535, 127, 1, stmc_pkg::ST_OK, 0, 0);
    add_row(stmc_pkg::OP_ALLOC, 1, 65535, 0, 1, stmc_pkg::ST_RANGE, 1, 0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_plan[i]) begin
      issue_request(directed_plan[i].req, directed_plan[i].fixed,
                    directed_plan[i].verdict, got);
      idle_for($urandom_range(0, 1) ? 0 : $urandom_range(1, 4));
    end
    drain_results();

    for (k = 0; k < N_RANDOM; k++) begin
      rq = random_request();
      issue_request(rq, 1'b0, none, got);
      track_blocks(rq, got);
      if ($urandom_range(0, 149) == 0) begin
        drain_results();
      end else if (k >= 700 && k < 1000) begin
        // back-to-back stretch
      end else if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 20);
        idle_for($urandom_range(1, 12));
      end
    end

    drain_results();
    repeat (40) @(posedge clk_i);
    $display("Ran %0d requests (%0d directed), %0d results checked, %0d reported an error.",
             n_accepted, directed_plan.size(), n_checked, n_flagged);
    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", n_fail);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/stmc_pkg.sv
rtl/shadow_tag_memory_checker_core.sv
tb/shadow_tag_memory_checker_core_tb.sv
